// ===== src/crt_pkg.sv =====
// Shared types, codes and defaults for the command/response tracker.
package crt_pkg;

  // Default sizes, handed to the top level's parameters
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int REVERSE_DEPTH_DEF = 32;

  // Fixed field widths
  localparam int SEQ_W   = 32;
  localparam int NSEQ_W  = 31;
  localparam int CODE_W  = 16;
  localparam int VAL_W   = 32;
  localparam int REV_W   = SEQ_W + CODE_W + VAL_W;

  typedef enum logic [1:0] {
    CMD_ISSUE    = 2'd0,
    CMD_RESPONSE = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_DRAIN    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    KIND_ISSUED          = 4'd0,
    KIND_COMPLETED       = 4'd1,
    KIND_NO_RESPONSE     = 4'd2,
    KIND_REVERSE_QUEUED  = 4'd3,
    KIND_REVERSE_DROPPED = 4'd4,
    KIND_REVERSE_POPPED  = 4'd5,
    KIND_REVERSE_EMPTY   = 4'd6,
    KIND_IGNORED         = 4'd7,
    KIND_CANCELLED       = 4'd8,
    KIND_PENDING_FULL    = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_REV,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TRIM
  } state_t;

endpackage

// ===== src/crt_if.sv =====
// Valid/ready channel interfaces for tracker commands and results.
interface crt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        want_reply;
  logic [31:0] seq;
  logic [15:0] code;
  logic [31:0] retval;

  modport source (output valid, command, want_reply, seq, code, retval, input ready);
  modport sink   (input valid, command, want_reply, seq, code, retval, output ready);
endinterface

interface crt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] tag;
  logic [15:0] reply_code;
  logic [31:0] reply_value;
  logic        last;

  modport source (output valid, kind, tag, reply_code, reply_value, last, input ready);
  modport sink   (input valid, kind, tag, reply_code, reply_value, last, output ready);
endinterface

// ===== src/crt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module crt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/command_response_tracker.sv =====
// Top level of the sequence-numbered command/response tracker.
//
//   port     | dir | handshake   | payload
//   ---------+-----+-------------+--------------------------------------------
//   in_if    | in  | valid/ready | command, want_reply, seq, code, retval
//   out_if   | out | valid/ready | kind, tag, reply_code, reply_value, last
//
// An item is taken only in the idle state; the pending sequence RAM and the
// reverse ring RAM (registered read) set the pace. Issue, reverse push and
// drain on empty emit from a single state; a drain that pops reads the ring
// first. A response or cancel steps through the pending entries, reading each
// valid one and passing or dropping invalid ones, stops at the end, at a match
// or at a newer entry, then trims invalid head entries.
// Reset (synchronous, active low) clears counters and valid bits at once;
// there is no clearing pass. A stalled result holds the sequencer in place where
// it must emit, and does not block acceptance of the next item once the current one ends.
module command_response_tracker
  import crt_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int REVERSE_DEPTH = REVERSE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  crt_cmd_if.sink     in_if,
  crt_rsp_if.source   out_if
);

  localparam int IDX_W  = $clog2(PENDING_DEPTH);
  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int RIDX_W = $clog2(REVERSE_DEPTH);

  localparam logic [CNT_W:0]    PD_SUM   = (CNT_W + 1)'(PENDING_DEPTH);
  localparam logic [CNT_W-1:0]  PD_CNT   = CNT_W'(PENDING_DEPTH);
  localparam logic [IDX_W-1:0]  PD_LAST  = IDX_W'(PENDING_DEPTH - 1);
  localparam logic [RIDX_W-1:0] RD_LAST  = RIDX_W'(REVERSE_DEPTH - 1);

  // control state
  state_t                state_r, state_nxt;
  logic [NSEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [IDX_W-1:0]      pend_head_r, pend_head_nxt;
  logic [CNT_W-1:0]      pend_count_r, pend_count_nxt;
  logic [CNT_W-1:0]      scan_off_r, scan_off_nxt;
  logic [PENDING_DEPTH-1:0] pend_valid_r, pend_valid_nxt;
  logic [RIDX_W-1:0]     rev_head_r, rev_head_nxt;
  logic [RIDX_W-1:0]     rev_tail_r, rev_tail_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // latched item
  cmd_t                  cmd_r;
  logic                  want_r;
  logic [SEQ_W-1:0]      seq_r;
  logic [CODE_W-1:0]     code_r;
  logic [VAL_W-1:0]      val_r;

  // result register payload
  kind_t                 out_kind_r;
  logic [SEQ_W-1:0]      out_tag_r;
  logic [CODE_W-1:0]     out_code_r;
  logic [VAL_W-1:0]      out_val_r;
  logic                  out_last_r;

  // emission request from the sequencer
  logic                  emit;
  kind_t                 emit_kind;
  logic [SEQ_W-1:0]      emit_tag;
  logic [CODE_W-1:0]     emit_code;
  logic [VAL_W-1:0]      emit_val;
  logic                  emit_last;

  logic                  in_fire;
  logic                  out_free;

  // RAM ports
  logic                  pend_wr_en, pend_rd_en;
  logic [NSEQ_W-1:0]     pend_rd_data;
  logic                  rev_wr_en, rev_rd_en;
  logic [REV_W-1:0]      rev_rd_data;

  // slot arithmetic: head plus offset, wrapped once
  logic [CNT_W:0]        scan_sum, tail_sum;
  logic [IDX_W-1:0]      scan_slot, tail_slot, head_inc;
  logic [RIDX_W-1:0]     rev_head_inc, rev_tail_inc;
  logic                  rev_full;
  logic [SEQ_W-1:0]      entry_seq;

  assign scan_sum  = {1'b0, CNT_W'(pend_head_r)} + {1'b0, scan_off_r};
  assign tail_sum  = {1'b0, CNT_W'(pend_head_r)} + {1'b0, pend_count_r};
  assign scan_slot = (scan_sum >= PD_SUM) ? IDX_W'(scan_sum - PD_SUM) : IDX_W'(scan_sum);
  assign tail_slot = (tail_sum >= PD_SUM) ? IDX_W'(tail_sum - PD_SUM) : IDX_W'(tail_sum);
  assign head_inc  = (pend_head_r == PD_LAST) ? '0 : pend_head_r + 1'b1;

  assign rev_head_inc = (rev_head_r == RD_LAST) ? '0 : rev_head_r + 1'b1;
  assign rev_tail_inc = (rev_tail_r == RD_LAST) ? '0 : rev_tail_r + 1'b1;
  assign rev_full     = (rev_head_inc == rev_tail_r);

  assign entry_seq = {1'b0, pend_rd_data};

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // pending sequence store
  crt_ram #(
    .WIDTH (NSEQ_W),
    .DEPTH (PENDING_DEPTH)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (pend_wr_en),
    .wr_addr (tail_slot),
    .wr_data (next_seq_r),
    .rd_en   (pend_rd_en),
    .rd_addr (scan_slot),
    .rd_data (pend_rd_data)
  );

  // reverse request ring
  crt_ram #(
    .WIDTH (REV_W),
    .DEPTH (REVERSE_DEPTH)
  ) u_rev_ram (
    .clk     (clk),
    .wr_en   (rev_wr_en),
    .wr_addr (rev_head_r),
    .wr_data ({seq_r, code_r, val_r}),
    .rd_en   (rev_rd_en),
    .rd_addr (rev_tail_r),
    .rd_data (rev_rd_data)
  );

  // sequencer: next state, queue updates and result selection
  always_comb begin
    state_nxt      = state_r;
    next_seq_nxt   = next_seq_r;
    pend_head_nxt  = pend_head_r;
    pend_count_nxt = pend_count_r;
    scan_off_nxt   = scan_off_r;
    pend_valid_nxt = pend_valid_r;
    rev_head_nxt   = rev_head_r;
    rev_tail_nxt   = rev_tail_r;
    pend_wr_en     = 1'b0;
    pend_rd_en     = 1'b0;
    rev_wr_en      = 1'b0;
    rev_rd_en      = 1'b0;
    emit           = 1'b0;
    emit_kind      = KIND_IGNORED;
    emit_tag       = seq_r;
    emit_code      = '0;
    emit_val       = '0;
    emit_last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          scan_off_nxt = '0;
          case (cmd_t'(in_if.command))
            CMD_ISSUE:    state_nxt = ST_ISSUE;
            CMD_RESPONSE: state_nxt = in_if.seq[SEQ_W-1] ? ST_REV : ST_SCAN_RD;
            CMD_CANCEL:   state_nxt = ST_SCAN_RD;
            CMD_DRAIN:    state_nxt = ST_DRAIN_RD;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end

      // take a sequence number, queue it if a reply is awaited; refused when one is and the FIFO is full
      ST_ISSUE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_tag  = {1'b0, next_seq_r};
          state_nxt = ST_IDLE;
          if (want_r && (pend_count_r == PD_CNT)) begin
            emit_kind = KIND_PENDING_FULL;
          end else begin
            emit_kind    = KIND_ISSUED;
            next_seq_nxt = next_seq_r + 1'b1;
            if (want_r) begin
              pend_wr_en                = 1'b1;
              pend_valid_nxt[tail_slot] = 1'b1;
              pend_count_nxt            = pend_count_r + 1'b1;
            end
          end
        end
      end

      // reverse request into the ring, dropped when the ring is full
      ST_REV: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          if (rev_full) begin
            emit_kind = KIND_REVERSE_DROPPED;
          end else begin
            emit_kind    = KIND_REVERSE_QUEUED;
            rev_wr_en    = 1'b1;
            rev_head_nxt = rev_head_inc;
          end
        end
      end

      ST_DRAIN_RD: begin
        if (rev_head_r == rev_tail_r) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_kind = KIND_REVERSE_EMPTY;
            emit_tag  = '0;
            state_nxt = ST_IDLE;
          end
        end else begin
          rev_rd_en = 1'b1;
          state_nxt = ST_DRAIN_OUT;
        end
      end

      ST_DRAIN_OUT: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_kind    = KIND_REVERSE_POPPED;
          emit_tag     = rev_rd_data[REV_W-1 -: SEQ_W];
          emit_code    = rev_rd_data[VAL_W +: CODE_W];
          emit_val     = rev_rd_data[VAL_W-1:0];
          rev_tail_nxt = rev_tail_inc;
          state_nxt    = ST_IDLE;
        end
      end

      // walk the pending FIFO: responses pop from the head, cancels step
      ST_SCAN_RD: begin
        if (scan_off_r == pend_count_r) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_kind = KIND_IGNORED;
            state_nxt = ST_TRIM;
          end
        end else if (!pend_valid_r[scan_slot]) begin
          if (cmd_r == CMD_RESPONSE) begin
            pend_valid_nxt[pend_head_r] = 1'b0;
            pend_head_nxt  = head_inc;
            pend_count_nxt = pend_count_r - 1'b1;
          end else begin
            scan_off_nxt = scan_off_r + 1'b1;
          end
        end else begin
          pend_rd_en = 1'b1;
          state_nxt  = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (out_free) begin
          if (entry_seq > seq_r) begin
            emit      = 1'b1;
            emit_kind = KIND_IGNORED;
            state_nxt = ST_TRIM;
          end else if (cmd_r == CMD_RESPONSE) begin
            pend_valid_nxt[pend_head_r] = 1'b0;
            pend_head_nxt  = head_inc;
            pend_count_nxt = pend_count_r - 1'b1;
            emit           = 1'b1;
            emit_tag       = entry_seq;
            if (entry_seq == seq_r) begin
              emit_kind = KIND_COMPLETED;
              emit_code = code_r;
              emit_val  = val_r;
              state_nxt = ST_TRIM;
            end else begin
              emit_kind = KIND_NO_RESPONSE;
              emit_last = 1'b0;
              state_nxt = ST_SCAN_RD;
            end
          end else if (entry_seq == seq_r) begin
            pend_valid_nxt[scan_slot] = 1'b0;
            emit      = 1'b1;
            emit_kind = KIND_CANCELLED;
            state_nxt = ST_TRIM;
          end else begin
            scan_off_nxt = scan_off_r + 1'b1;
            state_nxt    = ST_SCAN_RD;
          end
        end
      end

      // drop invalid entries at the head, one a cycle
      ST_TRIM: begin
        if ((pend_count_r != '0) && !pend_valid_r[pend_head_r]) begin
          pend_head_nxt  = head_inc;
          pend_count_nxt = pend_count_r - 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // queue pointers, counters and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r   <= '0;
      pend_head_r  <= '0;
      pend_count_r <= '0;
      scan_off_r   <= '0;
      pend_valid_r <= '0;
      rev_head_r   <= '0;
      rev_tail_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      next_seq_r   <= next_seq_nxt;
      pend_head_r  <= pend_head_nxt;
      pend_count_r <= pend_count_nxt;
      scan_off_r   <= scan_off_nxt;
      pend_valid_r <= pend_valid_nxt;
      rev_head_r   <= rev_head_nxt;
      rev_tail_r   <= rev_tail_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // accepted transaction fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_if.command);
      want_r <= in_if.want_reply;
      seq_r  <= in_if.seq;
      code_r <= in_if.code;
      val_r  <= in_if.retval;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_tag_r  <= emit_tag;
      out_code_r <= emit_code;
      out_val_r  <= emit_val;
      out_last_r <= emit_last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.tag         = out_tag_r;
  assign out_if.reply_code  = out_code_r;
  assign out_if.reply_value = out_val_r;
  assign out_if.last        = out_last_r;

  // pending FIFO never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_count_r <= PD_CNT)
    else $error("pending count beyond depth");

  // between items the head entry is valid whenever the FIFO is not empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && pend_count_r != '0) |-> pend_valid_r[pend_head_r])
    else $error("invalid entry left at pending head");

  // only a no_response result is followed by more results of the same item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_kind_r == KIND_NO_RESPONSE))
    else $error("non-final result of wrong kind");

  // a push never makes the ring look empty
  assert property (@(posedge clk) disable iff (!rst_n)
    rev_wr_en |=> (rev_head_r != rev_tail_r))
    else $error("reverse ring overrun");

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote a pending transaction");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the command/response tracker: random and directed traffic.
`timescale 1ns / 1ps

module tb;
  import crt_pkg::*;

  localparam int PEND_DEPTH = PENDING_DEPTH_DEF;
  localparam int REV_DEPTH  = REVERSE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    cmd_t        command;
    logic        want_reply;
    logic [31:0] seq;
    logic [15:0] code;
    logic [31:0] retval;
  } cmd_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] tag;
    logic [15:0] reply_code;
    logic [31:0] reply_value;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  crt_cmd_if in_ch();
  crt_rsp_if out_ch();

  command_response_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset and known input values from time zero
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ISSUE;
    in_ch.want_reply = 1'b0;
    in_ch.seq = '0;
    in_ch.code = '0;
    in_ch.retval = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  cmd_item_t stim_queue[$];
  result_t   expected_results[$];
  cmd_item_t on_bus;
  int        accepted_count = 0;
  int        stim_total = 0;
  int        mismatches = 0;

  // ---------------------------------------------------------------------
  // Tracker predictor state
  // ---------------------------------------------------------------------
  logic [30:0] trk_next = '0;
  logic [30:0] pend_seq [PEND_DEPTH];
  bit          pend_live [PEND_DEPTH];
  int unsigned pend_head = 0;
  int unsigned pend_count = 0;
  logic [31:0] rev_seq [REV_DEPTH];
  logic [15:0] rev_code [REV_DEPTH];
  logic [31:0] rev_val [REV_DEPTH];
  int unsigned rev_head = 0;
  int unsigned rev_tail = 0;

  function automatic void post_result(kind_t k, logic [31:0] tag, logic [15:0] rc,
                                      logic [31:0] rv);
    result_t r;
    r.kind = k;
    r.tag = tag;
    r.reply_code = rc;
    r.reply_value = rv;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void pop_pending();
    pend_live[pend_head] = 1'b0;
    pend_head = (pend_head + 1) % PEND_DEPTH;
    pend_count--;
  endfunction

  // Drop cancelled entries sitting at the head of the pending FIFO
  function automatic void trim_pending();
    while (pend_count > 0 && !pend_live[pend_head])
      pop_pending();
  endfunction

  // Work out the results of one accepted command transaction
  function automatic void track_command(cmd_item_t it);
    logic [31:0] e;
    bit done;
    bit hit;
    int unsigned s;
    int unsigned i;
    done = 1'b0;
    hit = 1'b0;
    case (it.command)
      CMD_ISSUE: begin
        if (it.want_reply && pend_count >= PEND_DEPTH) begin
          post_result(KIND_PENDING_FULL, {1'b0, trk_next}, '0, '0);
        end else begin
          if (it.want_reply) begin
            s = (pend_head + pend_count) % PEND_DEPTH;
            pend_seq[s] = trk_next;
            pend_live[s] = 1'b1;
            pend_count++;
          end
          post_result(KIND_ISSUED, {1'b0, trk_next}, '0, '0);
          trk_next = trk_next + 31'd1;
        end
      end
      CMD_RESPONSE: begin
        if (it.seq[31]) begin
          // reverse request: ring keeps one slot free
          if ((rev_head + 1) % REV_DEPTH == rev_tail) begin
            post_result(KIND_REVERSE_DROPPED, it.seq, '0, '0);
          end else begin
            rev_seq[rev_head] = it.seq;
            rev_code[rev_head] = it.code;
            rev_val[rev_head] = it.retval;
            rev_head = (rev_head + 1) % REV_DEPTH;
            post_result(KIND_REVERSE_QUEUED, it.seq, '0, '0);
          end
        end else begin
          // older entries are reported as lost, a match completes
          while (pend_count > 0 && !done) begin
            if (!pend_live[pend_head]) begin
              pop_pending();
            end else begin
              e = {1'b0, pend_seq[pend_head]};
              if (e > it.seq) begin
                done = 1'b1;
              end else begin
                pop_pending();
                if (e == it.seq) begin
                  post_result(KIND_COMPLETED, e, it.code, it.retval);
                  hit = 1'b1;
                  done = 1'b1;
                end else begin
                  post_result(KIND_NO_RESPONSE, e, '0, '0);
                end
              end
            end
          end
          if (!hit)
            post_result(KIND_IGNORED, it.seq, '0, '0);
          trim_pending();
        end
      end
      CMD_CANCEL: begin
        for (i = 0; i < pend_count && !done; i++) begin
          s = (pend_head + i) % PEND_DEPTH;
          if (pend_live[s]) begin
            if ({1'b0, pend_seq[s]} > it.seq) begin
              done = 1'b1;
            end else if ({1'b0, pend_seq[s]} == it.seq) begin
              pend_live[s] = 1'b0;
              hit = 1'b1;
              done = 1'b1;
            end
          end
        end
        post_result(hit ? KIND_CANCELLED : KIND_IGNORED, it.seq, '0, '0);
        trim_pending();
      end
      default: begin
        if (rev_head == rev_tail) begin
          post_result(KIND_REVERSE_EMPTY, '0, '0, '0);
        end else begin
          post_result(KIND_REVERSE_POPPED, rev_seq[rev_tail], rev_code[rev_tail],
                      rev_val[rev_tail]);
          rev_tail = (rev_tail + 1) % REV_DEPTH;
        end
      end
    endcase
    expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building, with a rough view of which tags are outstanding
  // ---------------------------------------------------------------------
  logic [30:0] gen_next = '0;
  logic [30:0] gen_open[$];

  function automatic void send(cmd_t c, logic want, logic [31:0] s, logic [15:0] cd,
                               logic [31:0] rv);
    cmd_item_t it;
    it.command = c;
    it.want_reply = want;
    it.seq = s;
    it.code = cd;
    it.retval = rv;
    stim_queue.push_back(it);
  endfunction

  function automatic void send_issue(logic want);
    send(CMD_ISSUE, want, $urandom, 16'($urandom_range(0, 65535)), $urandom);
    if (!want) begin
      gen_next = gen_next + 31'd1;
    end else if (gen_open.size() < PEND_DEPTH) begin
      gen_open.push_back(gen_next);
      gen_next = gen_next + 31'd1;
    end
  endfunction

  function automatic void send_response(logic [31:0] s, logic [15:0] cd, logic [31:0] rv);
    send(CMD_RESPONSE, 1'($urandom_range(0, 1)), s, cd, rv);
    if (!s[31])
      while (gen_open.size() != 0 && {1'b0, gen_open[0]} <= s)
        void'(gen_open.pop_front());
  endfunction

  function automatic void send_cancel(logic [31:0] s);
    int k;
    send(CMD_CANCEL, 1'($urandom_range(0, 1)), s, 16'($urandom_range(0, 65535)), $urandom);
    for (k = gen_open.size() - 1; k >= 0; k--)
      if ({1'b0, gen_open[k]} == s)
        gen_open.delete(k);
  endfunction

  function automatic void send_drain();
    send(CMD_DRAIN, 1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)),
         $urandom);
  endfunction

  // Mostly well-formed traffic around the outstanding tags, some noise
  function automatic void send_mixed(int n);
    int i;
    int pick;
    int lim;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      lim = (gen_open.size() > 4) ? 3 : gen_open.size() - 1;
      if (pick < 30) begin
        send_issue(1'b1);
      end else if (pick < 38) begin
        send_issue(1'b0);
      end else if (pick < 55) begin
        if (gen_open.size() != 0)
          send_response({1'b0, gen_open[$urandom_range(0, lim)]},
                        16'($urandom_range(0, 65535)), $urandom);
        else
          send_response({1'b0, gen_next - 31'($urandom_range(0, 3))},
                        16'($urandom_range(0, 65535)), $urandom);
      end else if (pick < 63) begin
        if (gen_open.size() != 0)
          send_cancel({1'b0, gen_open[$urandom_range(0, gen_open.size() - 1)]});
        else
          send_cancel({1'b0, gen_next});
      end else if (pick < 73) begin
        send_response($urandom | 32'h8000_0000, 16'($urandom_range(0, 65535)), $urandom);
      end else if (pick < 83) begin
        send_drain();
      end else begin
        // noise: any command, any field values
        case (cmd_t'($urandom_range(0, 3)))
          CMD_ISSUE:    send_issue(1'($urandom_range(0, 1)));
          CMD_RESPONSE: send_response($urandom, 16'($urandom_range(0, 65535)), $urandom);
          CMD_CANCEL:   send_cancel($urandom);
          default:      send_drain();
        endcase
      end
    end
  endfunction

  // Idle decision for both sides; a stretch without breaks in the middle of the run
  function automatic bit take_break();
    if (accepted_count >= 40 && accepted_count < 100)
      return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one command transaction at a time from stim_queue
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_command(on_bus);
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stim_queue.size() != 0 && !take_break()) begin
          on_bus = stim_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= on_bus.command;
          in_ch.want_reply <= on_bus.want_reply;
          in_ch.seq <= on_bus.seq;
          in_ch.code <= on_bus.code;
          in_ch.retval <= on_bus.retval;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest expectation
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d tag %h",
                   $time, out_ch.kind, out_ch.tag);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind", 32'(out_ch.kind), 32'(exp_r.kind));
          check_field("tag", out_ch.tag, exp_r.tag);
          check_field("reply_code", 32'(out_ch.reply_code), 32'(exp_r.reply_code));
          check_field("reply_value", out_ch.reply_value, exp_r.reply_value);
          check_field("last", 32'(out_ch.last), 32'(exp_r.last));
        end
      end
      out_ch.ready <= !take_break();
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------
  initial begin
    int k;
    // drain with nothing queued, issue without reply
    send_drain();
    send_issue(1'b0);
    // fill pending FIFO, then one refused issue
    for (k = 0; k < PEND_DEPTH; k++)
      send_issue(1'b1);
    send_issue(1'b1);
    // largest forward seq: every entry lost, then ignored
    send_response(32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // cancel in the middle, the scan skips it silently
    send_issue(1'b1);
    send_issue(1'b1);
    send_issue(1'b1);
    send_cancel({1'b0, gen_open[1]});
    send_response({1'b0, gen_open[1]}, 16'h0000, 32'h0000_0000);
    // reverse request with all-ones fields, popped straight back
    send_response(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_drain();

    send_mixed(30);
    // overrun the reverse ring, then empty it past the bottom
    for (k = 0; k < REV_DEPTH + 1; k++)
      send_response($urandom | 32'h8000_0000, 16'($urandom_range(0, 65535)), $urandom);
    for (k = 0; k < REV_DEPTH + 1; k++)
      send_drain();
    // run into pending full again, then mixed traffic from a full FIFO
    for (k = 0; k < PEND_DEPTH + 2; k++)
      send_issue(1'b1);
    send_mixed(20);

    stim_total = stim_queue.size();
    while (accepted_count < stim_total)
      @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** command_response_tracker: PASSED **");
    else
      $display("** command_response_tracker: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** command_response_tracker: FAILED **");
    $finish;
  end

endmodule
